[rtl/core/dppr_pkg.sv]
// Package for the deferred push/pop release queue.
// Types, codes and sizes shared by the controller, datapath and top level.
`default_nettype none
package dppr_pkg;
    localparam int STORE_DEPTH = 64;
    localparam int TAG_BITS = 16;
    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_EVENT = 2'd2;
    localparam logic [1:0] OP_FLUSH = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        hold_req;
        logic [15:0] tag;
    } in_item_t;

    typedef struct packed {
        logic [15:0] released_tag;
        logic [1:0]  released_kind;
        logic        status;
        logic        last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_READ,
        ST_EMIT,
        ST_TRIM_RD,
        ST_TRIM_CHK,
        ST_DROP
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;    // latch input item
        logic store;      // write new entry, update stacks
        logic rd_walk;    // read entry at release pointer
        logic emit_load;  // load output register from read entry
        logic emit_drop;  // load output register with dropped item
        logic emit_last;  // last flag for loaded result
        logic rd_trim;    // read entry at count-1
        logic trim_dec;   // drop tail entry
        logic trim_done;  // clamp release pointer
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       run_walk;   // after store: does a walk run
        logic       pending;    // release_pointer < entry_count
        logic       last_one;   // release_pointer+1 == entry_count
        logic       tail_del;   // tail entry deletable
        logic       count_nz;
        logic       out_free;   // output register can take a result
    } dp_stat_t;
endpackage
`default_nettype wire

[rtl/core/deferred_push_pop_release_queue.sv]
// Top level of the deferred push/pop release queue.
// Instantiates dppr_ctrl and dppr_datapath; depends on dppr_pkg.
//
// Usage: items (push, pop, event, flush) arrive on in_valid/in_ready with
// in_item. Results leave on out_valid/out_ready with out_item, one per
// released or dropped item, last set on the final result of an input.
// An item that causes no release is accepted, then decided. A release walk
// reads each released entry from the store, then loads the output
// register; it then reads and trims deletable tail entries and finishes;
// the walk runs serially over the single-port entry store.
// A dropped item (store full) yields one result.
// One input item is processed at a time; in_ready is high only between
// items. The output register holds a result while the receiver stalls
// and the walk waits on it. Reset empties the store, pointers and
// stacks at once; no clearing pass is needed.
`default_nettype none
module deferred_push_pop_release_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire dppr_pkg::in_item_t in_item,
    output logic                out_valid,
    input  wire logic           out_ready,
    output dppr_pkg::out_item_t out_item
);
    import dppr_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    dppr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dppr_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .stat      (stat),
        .out_item  (out_item),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );
endmodule
`default_nettype wire

[rtl/core/dppr_datapath.sv]
// Datapath of the release queue: entry store, open-push stacks, pointers,
// output register. Depends on dppr_pkg.
`default_nettype none
module dppr_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dppr_pkg::in_item_t in_item,
    input  wire dppr_pkg::dp_cmd_t  cmd,
    output dppr_pkg::dp_stat_t     stat,
    output dppr_pkg::out_item_t    out_item,
    output logic                   out_valid,
    input  wire logic              out_ready
);
    import dppr_pkg::*;

    // Entry store; partner MSB set means no partner
    logic [TAG_BITS-1:0] tag_mem [STORE_DEPTH];
    logic [1:0]          kind_mem [STORE_DEPTH];
    logic [IDX_W:0]      partner_mem [STORE_DEPTH];
    logic                del_mem [STORE_DEPTH];
    logic [IDX_W-1:0]    open_stack [STORE_DEPTH];
    logic                hold_stack [STORE_DEPTH];

    in_item_t         item_reg;
    logic [CNT_W-1:0] count_reg, rp_reg, opc_reg, hc_reg;
    logic             hold_top_reg;   // hold_stack top value, valid if hc>0
    logic [IDX_W-1:0] open_top_reg;   // open stack top
    logic             hold_below_reg; // entry under top
    logic [TAG_BITS-1:0] rd_tag_reg;
    logic [1:0]       rd_kind_reg;
    logic [IDX_W:0]   rd_part_reg;
    logic             rd_del_reg;
    out_item_t        out_reg;
    logic             out_valid_reg;

    logic             mark;
    logic [IDX_W-1:0] cidx, ridx, tidx;
    assign cidx = count_reg[IDX_W-1:0];
    assign ridx = rp_reg[IDX_W-1:0];
    assign tidx = IDX_W'(count_reg - CNT_W'(1));
    assign mark = item_reg.hold_req || (hc_reg != '0 && hold_top_reg);

    // Status
    always_comb
    begin
        stat.op       = item_reg.opcode;
        stat.full     = (count_reg == CNT_W'(STORE_DEPTH));
        stat.run_walk = (item_reg.opcode == OP_PUSH) ? !mark :
                        (item_reg.opcode == OP_POP) ?
                        !(hc_reg > CNT_W'(1) && hold_below_reg) : 1'b0;
        stat.pending  = (rp_reg < count_reg);
        stat.last_one = (rp_reg + CNT_W'(1) == count_reg);
        stat.tail_del = rd_del_reg;
        stat.count_nz = (count_reg != '0);
        stat.out_free = !out_valid_reg || out_ready;
    end

    // Input capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= in_item;
    end

    // Memories: store, walk read, trim read
    always_ff @(posedge clk)
    begin
        if (cmd.store) begin
            tag_mem[cidx]     <= item_reg.tag;
            kind_mem[cidx]    <= item_reg.opcode;
            del_mem[cidx]     <= (item_reg.opcode == OP_EVENT);
            if (item_reg.opcode == OP_PUSH && hc_reg < CNT_W'(STORE_DEPTH)) begin
                hold_stack[hc_reg[IDX_W-1:0]] <= mark;
                open_stack[opc_reg[IDX_W-1:0]] <= cidx;
            end
            // A pop links to the newest open push; anything else has no partner
            if (item_reg.opcode == OP_POP && opc_reg != '0) begin
                partner_mem[cidx] <= {1'b0, open_top_reg};
                partner_mem[open_top_reg] <= {1'b0, cidx};
            end else
                partner_mem[cidx] <= {1'b1, {IDX_W{1'b0}}};
        end
        if (cmd.emit_load) begin
            if (rd_kind_reg == OP_POP)
                del_mem[ridx - IDX_W'(1)] <= 1'b1;
            if (!rd_part_reg[IDX_W] && rd_part_reg[IDX_W-1:0] < ridx - IDX_W'(1))
                del_mem[rd_part_reg[IDX_W-1:0]] <= 1'b1;
        end
        if (cmd.rd_walk) begin
            rd_tag_reg  <= tag_mem[ridx];
            rd_kind_reg <= kind_mem[ridx];
            rd_part_reg <= partner_mem[ridx];
        end
        if (cmd.rd_trim)
            rd_del_reg <= del_mem[tidx];
    end

    // Stack top caches, refreshed when an item is captured
    always_ff @(posedge clk)
    begin
        if (cmd.capture) begin
            hold_top_reg   <= hold_stack[IDX_W'(hc_reg - CNT_W'(1))];
            hold_below_reg <= hold_stack[IDX_W'(hc_reg - CNT_W'(2))];
            open_top_reg   <= open_stack[IDX_W'(opc_reg - CNT_W'(1))];
        end
    end

    // Counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
            rp_reg    <= '0;
            opc_reg   <= '0;
            hc_reg    <= '0;
        end else begin
            if (cmd.store) begin
                count_reg <= count_reg + CNT_W'(1);
                if (item_reg.opcode == OP_PUSH && hc_reg < CNT_W'(STORE_DEPTH)
                    && opc_reg < CNT_W'(STORE_DEPTH)) begin
                    hc_reg  <= hc_reg + CNT_W'(1);
                    opc_reg <= opc_reg + CNT_W'(1);
                end
                if (item_reg.opcode == OP_POP) begin
                    if (opc_reg != '0) opc_reg <= opc_reg - CNT_W'(1);
                    if (hc_reg != '0)  hc_reg  <= hc_reg - CNT_W'(1);
                end
            end
            if (cmd.rd_walk)
                rp_reg <= rp_reg + CNT_W'(1);
            if (cmd.trim_dec)
                count_reg <= count_reg - CNT_W'(1);
            if (cmd.trim_done && rp_reg > count_reg)
                rp_reg <= count_reg;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit_load || cmd.emit_drop)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load) begin
            out_reg.released_tag  <= rd_tag_reg;
            out_reg.released_kind <= rd_kind_reg;
            out_reg.status        <= 1'b0;
            out_reg.last          <= cmd.emit_last;
        end else if (cmd.emit_drop) begin
            out_reg.released_tag  <= item_reg.tag;
            out_reg.released_kind <= item_reg.opcode;
            out_reg.status        <= 1'b1;
            out_reg.last          <= 1'b1;
        end
    end

    assign out_item  = out_reg;
    assign out_valid = out_valid_reg;
endmodule
`default_nettype wire

[rtl/core/dppr_ctrl.sv]
// Controller state machine of the release queue.
// Depends on dppr_pkg.
`default_nettype none
module dppr_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire dppr_pkg::dp_stat_t stat,
    output dppr_pkg::dp_cmd_t  cmd
);
    import dppr_pkg::*;

    state_t state_reg, state_next;
    logic   last_reg, last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid) state_next = ST_DECIDE;
            ST_DECIDE:
                if (stat.op == OP_FLUSH)
                    state_next = stat.pending ? ST_READ : ST_TRIM_RD;
                else if (stat.full)
                    state_next = ST_DROP;
                else if (stat.run_walk)
                    state_next = ST_READ; // store this cycle, pending after
                else
                    state_next = ST_IDLE;
            ST_READ:
                if (stat.pending) begin
                    state_next = ST_EMIT;
                    last_next  = stat.last_one;
                end else
                    state_next = ST_TRIM_RD;
            ST_EMIT:
                if (stat.out_free)
                    state_next = last_reg ? ST_TRIM_RD : ST_READ;
            ST_TRIM_RD:
                state_next = stat.count_nz ? ST_TRIM_CHK : ST_IDLE;
            ST_TRIM_CHK:
                state_next = stat.tail_del ? ST_TRIM_RD : ST_IDLE;
            ST_DROP:
                if (stat.out_free) state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_DECIDE:
                cmd.store = (stat.op != OP_FLUSH) && !stat.full;
            ST_READ:
                cmd.rd_walk = stat.pending;
            ST_EMIT: begin
                cmd.emit_load = stat.out_free;
                cmd.emit_last = last_reg;
            end
            ST_TRIM_RD:
                if (stat.count_nz) cmd.rd_trim = 1'b1;
                else cmd.trim_done = 1'b1;
            ST_TRIM_CHK:
                if (stat.tail_del) cmd.trim_dec = 1'b1;
                else cmd.trim_done = 1'b1;
            ST_DROP:
                cmd.emit_drop = stat.out_free;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

[bench/tb_top.sv]
// Testbench for the deferred push/pop release queue.
// Drives push, pop, event and flush items, predicts releases and drops, checks results.
// Depends on dppr_pkg and deferred_push_pop_release_queue.
`default_nettype none
module tb_top;
    import dppr_pkg::*;

    localparam int DEPTH = STORE_DEPTH;
    localparam int NOTE_NONE = 127;
    localparam int LIMIT_CYCLES = 4000000;
    localparam int N_RANDOM = 360;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_item;
    logic out_valid;
    logic out_ready;
    out_item_t out_item;

    deferred_push_pop_release_queue dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Predictor state: stored entries, release pointer, open pushes and wait marks
    logic [15:0] q_tag [DEPTH];
    logic [1:0]  q_kind [DEPTH];
    int          q_partner [DEPTH];
    bit          q_del [DEPTH];
    int          q_count;
    int          rel_ptr;
    int          open_push [DEPTH];
    int          open_cnt;
    bit          hold_mark [DEPTH];
    int          hold_cnt;

    out_item_t   expected_releases [$];
    int          errors;
    int          n_results;
    int          n_drops;
    int          n_flush;
    longint      cycles;
    bit          stall_long;

    // Queue one predicted result
    task automatic add_release(logic [15:0] t, logic [1:0] k, logic st);
        out_item_t r;
        begin
            r.released_tag = t;
            r.released_kind = k;
            r.status = st;
            r.last = 1'b0;
            expected_releases.push_back(r);
        end
    endtask

    // Release every pending entry, then trim deletable entries from the tail
    task automatic walk_and_trim();
        int i;
        int p;
        begin
            while (rel_ptr < q_count)
            begin
                i = rel_ptr;
                p = q_partner[i];
                add_release(q_tag[i], q_kind[i], 1'b0);
                rel_ptr++;
                if (q_kind[i] == OP_POP)
                    q_del[i] = 1'b1;
                if (p < i)
                    q_del[p] = 1'b1;
            end
            while (q_count > 0 && q_del[q_count - 1])
                q_count--;
            if (rel_ptr > q_count)
                rel_ptr = q_count;
        end
    endtask

    // Apply one accepted item to the predictor
    task automatic predict_item(in_item_t it);
        int n_prior;
        int idx;
        int p;
        bit mark;
        bit run;
        out_item_t r;
        begin
            n_prior = expected_releases.size();
            if (it.opcode == OP_FLUSH)
            begin
                n_flush++;
                walk_and_trim();
            end
            else if (q_count >= DEPTH)
            begin
                add_release(it.tag, it.opcode, 1'b1);
            end
            else
            begin
                idx = q_count;
                q_tag[idx] = it.tag;
                q_kind[idx] = it.opcode;
                q_partner[idx] = NOTE_NONE;
                q_del[idx] = (it.opcode == OP_EVENT);
                q_count++;
                if (it.opcode == OP_PUSH)
                begin
                    mark = it.hold_req;
                    if (hold_cnt > 0 && hold_mark[hold_cnt - 1])
                        mark = 1'b1;
                    if (hold_cnt < DEPTH && open_cnt < DEPTH)
                    begin
                        hold_mark[hold_cnt++] = mark;
                        open_push[open_cnt++] = idx;
                    end
                    if (!mark)
                        walk_and_trim();
                end
                else if (it.opcode == OP_POP)
                begin
                    run = 1'b1;
                    if (open_cnt > 0)
                    begin
                        open_cnt--;
                        p = open_push[open_cnt];
                        q_partner[idx] = p;
                        q_partner[p] = idx;
                    end
                    if (hold_cnt > 0)
                    begin
                        hold_cnt--;
                        if (hold_cnt > 0 && hold_mark[hold_cnt - 1])
                            run = 1'b0;
                    end
                    if (run)
                        walk_and_trim();
                end
            end
            if (expected_releases.size() > n_prior)
            begin
                r = expected_releases[$];
                r.last = 1'b1;
                expected_releases[$] = r;
            end
        end
    endtask

    // Directed table; expected is typed in only where obvious, else predicted
    typedef struct {
        in_item_t  item;
        bit        known;
        out_item_t first_out;
    } dir_row_t;

    dir_row_t dir_rows [$];
    in_item_t stim [$];

    function automatic in_item_t mk(logic [1:0] op, logic w, logic [15:0] t);
        in_item_t it;
        begin
            it.opcode = op;
            it.hold_req = w;
            it.tag = t;
            return it;
        end
    endfunction

    task automatic add_row(logic [1:0] op, logic w, logic [15:0] t, bit k,
                           logic [1:0] ek);
        dir_row_t d;
        begin
            d.item = mk(op, w, t);
            d.known = k;
            d.first_out.released_tag = t;
            d.first_out.released_kind = ek;
            d.first_out.status = 1'b0;
            d.first_out.last = 1'b1;
            dir_rows.push_back(d);
        end
    endtask

    // Random well-formed nests with random content, plus noise
    task automatic build_random();
        int n;
        int depth;
        int sel;
        begin
            n = 0;
            depth = 0;
            while (n < N_RANDOM)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 35 && depth < 8)
                begin
                    stim.push_back(mk(OP_PUSH, 1'($urandom_range(0, 1)), 16'($urandom)));
                    depth++;
                end
                else if (sel < 70 && depth > 0)
                begin
                    stim.push_back(mk(OP_POP, 1'($urandom_range(0, 1)), 16'($urandom)));
                    depth--;
                end
                else if (sel < 88)
                    stim.push_back(mk(OP_EVENT, 1'($urandom_range(0, 1)), 16'($urandom)));
                else if (sel < 94)
                    stim.push_back(mk(OP_FLUSH, 1'($urandom_range(0, 1)), 16'($urandom)));
                else
                    stim.push_back(mk(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                      16'($urandom)));
                n++;
            end
            stim.push_back(mk(OP_FLUSH, 1'b0, 16'h0));
        end
    endtask

    // Sender: one item at a time, random gap before each; valid stays up on no gap
    task automatic send_item(in_item_t it);
        int gap;
        begin
            gap = $urandom_range(0, 14);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_item <= it;
            in_valid <= 1'b1;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            predict_item(it);
            @(negedge clk);
        end
    endtask

    // Receiver: random stall per result; one long hold-off when asked
    initial
    begin
        int w;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_long)
            begin
                out_ready <= 1'b0;
                repeat (400) @(negedge clk);
                stall_long = 1'b0;
            end
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (w > 0)
            begin
                out_ready <= 1'b0;
                repeat (w) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            if (out_item.status)
                n_drops++;
            if (expected_releases.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result tag=%h kind=%0d status=%0d last=%0d",
                         $time, out_item.released_tag, out_item.released_kind,
                         out_item.status, out_item.last);
            end
            else
            begin
                e = expected_releases.pop_front();
                if (e !== out_item)
                begin
                    errors++;
                    $display("%0t: mismatch exp tag=%h kind=%0d st=%0d last=%0d",
                             $time, e.released_tag, e.released_kind, e.status, e.last);
                    $display("%0t:          got tag=%h kind=%0d st=%0d last=%0d",
                             $time, out_item.released_tag, out_item.released_kind,
                             out_item.status, out_item.last);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        int k;
        int drain;
        out_item_t peek;
        errors = 0;
        n_results = 0;
        n_drops = 0;
        n_flush = 0;
        cycles = 0;
        stall_long = 1'b0;
        q_count = 0;
        rel_ptr = 0;
        open_cnt = 0;
        hold_cnt = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: flush on empty, lone event, extremes of tag, plain pushes/pops,
        // pop without open push, waiting push, nested push inheriting the wait
        add_row(OP_FLUSH, 1'b1, 16'hFFFF, 1'b0, OP_PUSH);
        add_row(OP_EVENT, 1'b0, 16'h0000, 1'b0, OP_EVENT);
        add_row(OP_PUSH, 1'b0, 16'hFFFF, 1'b0, OP_PUSH);
        add_row(OP_POP, 1'b0, 16'h0000, 1'b1, OP_POP);
        add_row(OP_POP, 1'b1, 16'h1234, 1'b1, OP_POP);
        add_row(OP_PUSH, 1'b1, 16'hA5A5, 1'b0, OP_PUSH);
        add_row(OP_PUSH, 1'b0, 16'h5A5A, 1'b0, OP_PUSH);
        add_row(OP_EVENT, 1'b1, 16'h8000, 1'b0, OP_EVENT);
        add_row(OP_POP, 1'b0, 16'h0001, 1'b0, OP_POP);
        add_row(OP_POP, 1'b0, 16'h7FFF, 1'b0, OP_POP);
        add_row(OP_PUSH, 1'b1, 16'h00FF, 1'b0, OP_PUSH);
        add_row(OP_EVENT, 1'b0, 16'hFF00, 1'b0, OP_EVENT);
        add_row(OP_FLUSH, 1'b0, 16'h0000, 1'b0, OP_PUSH);
        add_row(OP_POP, 1'b1, 16'hC3C3, 1'b0, OP_POP);
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].known)
            begin
                // Typed-in: single release of this item, last set
                k = expected_releases.size();
                send_item(dir_rows[i].item);
                if (expected_releases.size() > k)
                begin
                    peek = expected_releases[k];
                    if (peek !== dir_rows[i].first_out)
                    begin
                        errors++;
                        $display("%0t: table row %0d exp tag=%h kind=%0d got tag=%h kind=%0d",
                                 $time, i, dir_rows[i].first_out.released_tag,
                                 dir_rows[i].first_out.released_kind,
                                 peek.released_tag, peek.released_kind);
                    end
                end
            end
            else
                send_item(dir_rows[i].item);
        end

        // Fill the store under a waiting push while the receiver holds off,
        // then overflow it so further items drop, then flush it
        stall_long = 1'b1;
        send_item(mk(OP_PUSH, 1'b1, 16'hBEEF));
        for (int j = 0; j < DEPTH + 4; j++)
            send_item(mk(OP_EVENT, j[0], 16'($urandom)));
        send_item(mk(OP_PUSH, 1'b0, 16'hDEAD));
        send_item(mk(OP_POP, 1'b1, 16'hFACE));
        send_item(mk(OP_FLUSH, 1'b0, 16'h0));
        // Unwind any pushes still open so random part starts clean
        while (open_cnt > 0)
            send_item(mk(OP_POP, 1'b0, 16'($urandom)));
        send_item(mk(OP_FLUSH, 1'b0, 16'h0));

        build_random();
        foreach (stim[i])
            send_item(stim[i]);
        in_valid <= 1'b0;

        drain = 0;
        while (expected_releases.size() > 0 && drain < 200000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (300) @(posedge clk);
        $display("Covered %0d results (%0d drops), %0d flushes,", n_results, n_drops, n_flush);
        $display("nested waiting pushes, a full store and a long receiver stall.");
        if (errors == 0 && expected_releases.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
